>>> src/tepm_pkg.sv
`timescale 1ns / 1ps

package tepm_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TS_W   = 48;
  localparam int unsigned WIN_W  = 24;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned PEND_W = 5;
  localparam int unsigned OP_W   = 2;

  localparam logic [WIN_W-1:0] WIN_RESET = 24'd50000;

  localparam int unsigned OUT_FIELDS_W = 5 * CNT_W + 2 * TS_W + 2 * PEND_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REF  = 2'd0,
    OP_PUSH_CAND = 2'd1,
    OP_MATCH     = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_EXPIRY,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_PAIR_ACC,
    ST_REF_RD,
    ST_REF_CMP,
    ST_CAND_RD,
    ST_CAND_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

endpackage

>>> src/timestamp_event_pair_matcher.sv
`timescale 1ns / 1ps

// timestamp event pair matcher
// s_axis carries one transaction per event: tuser selects push reference,
// push candidate or match, tdata holds the timestamp (or current time).
// every accepted transaction yields exactly one m_axis transaction with the
// counters, delta sum, largest delta and queue fills after that item.
// cfg_* writes the 24 bit match window; write it only while the block is idle.
// a push goes from the accepting cycle through the push state to the emit state;
// a match computes the expiry bound, runs pairing steps while both queues hold
// entries (at most 31 pairing steps at depth 16), then checks the reference head
// and then the candidate head in the expiry pass until each queue is empty or its
// head is kept, and then emits; each head compare waits on the registered read of the two queue memories.
// one item is in work at a time; the next is accepted as soon as the result
// has moved into the output register, even while m_axis is stalled.
// a stalled m_axis holds the result and blocks only the following result.
// reset empties both queues, clears all counters and the delta sum, and
// sets the window to 50000 us; queue memories need no clearing.

module timestamp_event_pair_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,     // match_window_us
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // event time in us
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // matched_count, reference_only_count, candidate_only_count, reference_total,
  // candidate_total, delta_sum_us, max_abs_delta_us, reference_pending,
  // candidate_pending, zero padding
  output logic [tepm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned TS_W  = tepm_pkg::TS_W;
  localparam int unsigned CNT_W = tepm_pkg::CNT_W;

  tepm_pkg::state_e state_q, state_d;

  logic [tepm_pkg::WIN_W-1:0] win_q;
  tepm_pkg::op_e              op_q;
  logic [TS_W-1:0]            ts_q;
  logic [TS_W-1:0]            expiry_q;

  logic [CNT_W-1:0] matched_q, ref_only_q, cand_only_q, ref_total_q, cand_total_q;
  logic [TS_W-1:0]  acc_q;
  logic [TS_W-1:0]  max_q;

  logic [TS_W:0]    diff_q;
  logic [TS_W-1:0]  mag_q;
  logic             c_gt_r_q;

  logic                             out_valid_q;
  logic [tepm_pkg::OUT_TDATA_W-1:0] out_data_q;

  tepm_pkg::q_cmd_t             ref_cmd, cand_cmd;
  logic [TS_W-1:0]              ref_head, cand_head;
  logic [tepm_pkg::FILL_W-1:0]  ref_fill, cand_fill;
  logic                         ref_full, cand_full, ref_empty, cand_empty;

  logic            in_accept;
  logic            out_free;
  logic [TS_W:0]   now_minus_win;
  logic [TS_W:0]   diff_cr, diff_rc;
  logic            in_win;
  logic [TS_W+1:0] acc_sum;
  logic [TS_W-1:0] acc_sat;
  logic            ref_expired, cand_expired;

  logic inc_matched, inc_ref_only, inc_cand_only, inc_ref_total, inc_cand_total;
  logic acc_en, expiry_en, diff_en, emit_load;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  tepm_queue u_ref_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ref_cmd),
    .wdata_i     (ts_q),
    .head_data_o (ref_head),
    .fill_o      (ref_fill)
  );

  tepm_queue u_cand_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cand_cmd),
    .wdata_i     (ts_q),
    .head_data_o (cand_head),
    .fill_o      (cand_fill)
  );

  assign ref_full   = (ref_fill == tepm_pkg::FILL_W'(tepm_pkg::QUEUE_DEPTH));
  assign cand_full  = (cand_fill == tepm_pkg::FILL_W'(tepm_pkg::QUEUE_DEPTH));
  assign ref_empty  = (ref_fill == '0);
  assign cand_empty = (cand_fill == '0);

  assign cfg_ready_o   = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // datapath
  assign now_minus_win = {1'b0, ts_q} - {{(TS_W + 1 - tepm_pkg::WIN_W){1'b0}}, win_q};
  assign diff_cr       = {1'b0, cand_head} - {1'b0, ref_head};
  assign diff_rc       = {1'b0, ref_head} - {1'b0, cand_head};
  assign in_win        = (mag_q <= {{(TS_W - tepm_pkg::WIN_W){1'b0}}, win_q});
  assign acc_sum       = {{2{acc_q[TS_W-1]}}, acc_q} + {diff_q[TS_W], diff_q};
  assign ref_expired   = (ref_head < expiry_q);
  assign cand_expired  = (cand_head < expiry_q);

  // clamp to the 48 bit signed range
  always_comb begin
    if ((acc_sum[TS_W+1] == acc_sum[TS_W]) && (acc_sum[TS_W] == acc_sum[TS_W-1])) begin
      acc_sat = acc_sum[TS_W-1:0];
    end else if (acc_sum[TS_W+1]) begin
      acc_sat = {1'b1, {(TS_W - 1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(TS_W - 1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tepm_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (s_axis_tuser)
            tepm_pkg::OP_PUSH_REF,
            tepm_pkg::OP_PUSH_CAND: state_d = tepm_pkg::ST_PUSH;
            tepm_pkg::OP_MATCH:     state_d = tepm_pkg::ST_EXPIRY;
            default:                state_d = tepm_pkg::ST_EMIT;
          endcase
        end
      end
      tepm_pkg::ST_PUSH:     state_d = tepm_pkg::ST_EMIT;
      tepm_pkg::ST_EXPIRY:   state_d = tepm_pkg::ST_PAIR_RD;
      tepm_pkg::ST_PAIR_RD: begin
        state_d = (ref_empty || cand_empty) ? tepm_pkg::ST_REF_RD : tepm_pkg::ST_PAIR_CMP;
      end
      tepm_pkg::ST_PAIR_CMP: state_d = tepm_pkg::ST_PAIR_ACC;
      tepm_pkg::ST_PAIR_ACC: state_d = tepm_pkg::ST_PAIR_RD;
      tepm_pkg::ST_REF_RD: begin
        state_d = ref_empty ? tepm_pkg::ST_CAND_RD : tepm_pkg::ST_REF_CMP;
      end
      tepm_pkg::ST_REF_CMP: begin
        state_d = ref_expired ? tepm_pkg::ST_REF_RD : tepm_pkg::ST_CAND_RD;
      end
      tepm_pkg::ST_CAND_RD: begin
        state_d = cand_empty ? tepm_pkg::ST_EMIT : tepm_pkg::ST_CAND_CMP;
      end
      tepm_pkg::ST_CAND_CMP: begin
        state_d = cand_expired ? tepm_pkg::ST_CAND_RD : tepm_pkg::ST_EMIT;
      end
      tepm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = tepm_pkg::ST_IDLE;
        end
      end
      default: state_d = tepm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready  = 1'b0;
    ref_cmd        = '0;
    cand_cmd       = '0;
    inc_matched    = 1'b0;
    inc_ref_only   = 1'b0;
    inc_cand_only  = 1'b0;
    inc_ref_total  = 1'b0;
    inc_cand_total = 1'b0;
    acc_en         = 1'b0;
    expiry_en      = 1'b0;
    diff_en        = 1'b0;
    emit_load      = 1'b0;
    unique case (state_q)
      tepm_pkg::ST_IDLE: s_axis_tready = 1'b1;
      tepm_pkg::ST_PUSH: begin
        if (op_q == tepm_pkg::OP_PUSH_REF) begin
          ref_cmd.push  = 1'b1;
          inc_ref_total = 1'b1;
          inc_ref_only  = ref_full;
        end else begin
          cand_cmd.push  = 1'b1;
          inc_cand_total = 1'b1;
          inc_cand_only  = cand_full;
        end
      end
      tepm_pkg::ST_EXPIRY:   expiry_en = 1'b1;
      tepm_pkg::ST_PAIR_CMP: diff_en   = 1'b1;
      tepm_pkg::ST_PAIR_ACC: begin
        if (in_win) begin
          inc_matched  = 1'b1;
          acc_en       = 1'b1;
          ref_cmd.pop  = 1'b1;
          cand_cmd.pop = 1'b1;
        end else if (c_gt_r_q) begin
          inc_ref_only = 1'b1;
          ref_cmd.pop  = 1'b1;
        end else begin
          inc_cand_only = 1'b1;
          cand_cmd.pop  = 1'b1;
        end
      end
      tepm_pkg::ST_REF_CMP: begin
        inc_ref_only = ref_expired;
        ref_cmd.pop  = ref_expired;
      end
      tepm_pkg::ST_CAND_CMP: begin
        inc_cand_only = cand_expired;
        cand_cmd.pop  = cand_expired;
      end
      tepm_pkg::ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tepm_pkg::ST_IDLE;
      win_q        <= tepm_pkg::WIN_RESET;
      matched_q    <= '0;
      ref_only_q   <= '0;
      cand_only_q  <= '0;
      ref_total_q  <= '0;
      cand_total_q <= '0;
      acc_q        <= '0;
      max_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        win_q <= cfg_data_i;
      end
      if (inc_matched)    matched_q    <= sat_inc(matched_q);
      if (inc_ref_only)   ref_only_q   <= sat_inc(ref_only_q);
      if (inc_cand_only)  cand_only_q  <= sat_inc(cand_only_q);
      if (inc_ref_total)  ref_total_q  <= sat_inc(ref_total_q);
      if (inc_cand_total) cand_total_q <= sat_inc(cand_total_q);
      if (acc_en) begin
        acc_q <= acc_sat;
        if (mag_q > max_q) begin
          max_q <= mag_q;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= tepm_pkg::op_e'(s_axis_tuser);
      ts_q <= s_axis_tdata;
    end
    // expiry bound is zero while the current time has not passed the window
    if (expiry_en) begin
      expiry_q <= now_minus_win[TS_W] ? '0 : now_minus_win[TS_W-1:0];
    end
    if (diff_en) begin
      diff_q   <= diff_cr;
      mag_q    <= diff_cr[TS_W] ? diff_rc[TS_W-1:0] : diff_cr[TS_W-1:0];
      c_gt_r_q <= !diff_cr[TS_W];
    end
    if (emit_load) begin
      out_data_q <= tepm_pkg::OUT_TDATA_W'({
        tepm_pkg::PEND_W'(cand_fill),
        tepm_pkg::PEND_W'(ref_fill),
        max_q,
        acc_q,
        cand_total_q,
        ref_total_q,
        cand_only_q,
        ref_only_q,
        matched_q
      });
    end
  end

endmodule

>>> src/tepm_queue.sv
`timescale 1ns / 1ps

module tepm_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tepm_pkg::q_cmd_t            cmd_i,
  input  logic [tepm_pkg::TS_W-1:0]   wdata_i,
  output logic [tepm_pkg::TS_W-1:0]   head_data_o,
  output logic [tepm_pkg::FILL_W-1:0] fill_o
);

  localparam int unsigned SUM_W = tepm_pkg::IDX_W + 1;

  logic [tepm_pkg::TS_W-1:0]   mem [tepm_pkg::QUEUE_DEPTH];
  logic [tepm_pkg::TS_W-1:0]   rdata_q;
  logic [tepm_pkg::IDX_W-1:0]  head_q, head_d, head_next;
  logic [tepm_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]            tail_sum;
  logic [tepm_pkg::IDX_W-1:0]  waddr;
  logic                        full;

  assign full = (fill_q == tepm_pkg::FILL_W'(tepm_pkg::QUEUE_DEPTH));

  assign head_next = (head_q == tepm_pkg::IDX_W'(tepm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : head_q + tepm_pkg::IDX_W'(1);

  // tail slot is (head + fill) mod depth; a full queue overwrites its head
  assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
  assign waddr    = (tail_sum >= SUM_W'(tepm_pkg::QUEUE_DEPTH)) ?
                    tepm_pkg::IDX_W'(tail_sum - SUM_W'(tepm_pkg::QUEUE_DEPTH)) :
                    tepm_pkg::IDX_W'(tail_sum);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      if (full) begin
        head_d = head_next;
      end else begin
        fill_d = fill_q + tepm_pkg::FILL_W'(1);
      end
    end else if (cmd_i.pop && (fill_q != '0)) begin
      head_d = head_next;
      fill_d = fill_q - tepm_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[waddr] <= wdata_i;
    end
    rdata_q <= mem[head_q];
  end

  assign head_data_o = rdata_q;
  assign fill_o      = fill_q;

endmodule

>>> test/tb_timestamp_event_pair_matcher.sv
`timescale 1ns / 1ps

module tb_timestamp_event_pair_matcher;

  localparam int unsigned OP_W         = tepm_pkg::OP_W;
  localparam int unsigned TS_W         = tepm_pkg::TS_W;
  localparam int unsigned WIN_W        = tepm_pkg::WIN_W;
  localparam int unsigned CNT_W        = tepm_pkg::CNT_W;
  localparam int unsigned PEND_W       = tepm_pkg::PEND_W;
  localparam int unsigned OUT_TDATA_W  = tepm_pkg::OUT_TDATA_W;
  localparam int unsigned OUT_FIELDS_W = tepm_pkg::OUT_FIELDS_W;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam logic [TS_W-1:0] TS_MAX         = 48'hFFFF_FFFF_FFFF;
  localparam longint          SUM_HI         = 64'sd140737488355327;
  localparam longint          SUM_LO         = -64'sd140737488355328;
  localparam int unsigned     WATCHDOG_LIMIT = 4000;
  localparam int unsigned     SETTLE_CYCLES  = 200;
  localparam int unsigned     LONG_HOLD      = 400;
  localparam int unsigned     HOLD_AFTER     = 600;
  localparam int unsigned     SCENE_ITEMS    = 230;

  typedef enum logic [1:0] {
    K_EVENT,
    K_WINDOW,
    K_SETTLE
  } job_kind_e;

  typedef struct packed {
    job_kind_e       kind;
    logic [OP_W-1:0] op;
    logic [TS_W-1:0] ts;
  } job_t;

  // lowest field last, so the packed layout matches m_axis_tdata
  typedef struct packed {
    logic [PEND_W-1:0] cand_pend;
    logic [PEND_W-1:0] ref_pend;
    logic [TS_W-1:0]   max_abs;
    logic [TS_W-1:0]   delta_sum;
    logic [CNT_W-1:0]  cand_total;
    logic [CNT_W-1:0]  ref_total;
    logic [CNT_W-1:0]  cand_only;
    logic [CNT_W-1:0]  ref_only;
    logic [CNT_W-1:0]  matched;
  } tally_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [WIN_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TS_W-1:0]        s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  timestamp_event_pair_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow state of the matcher
  logic [WIN_W-1:0] window_us    = tepm_pkg::WIN_RESET;
  logic [TS_W-1:0]  ref_ts_q[$];
  logic [TS_W-1:0]  cand_ts_q[$];
  logic [CNT_W-1:0] matched_n    = '0;
  logic [CNT_W-1:0] ref_only_n   = '0;
  logic [CNT_W-1:0] cand_only_n  = '0;
  logic [CNT_W-1:0] ref_total_n  = '0;
  logic [CNT_W-1:0] cand_total_n = '0;
  longint           delta_acc    = 0;
  logic [TS_W-1:0]  max_dist     = '0;

  job_t        job_q[$];
  tally_t      tally_due_q[$];
  int unsigned events_in      = 0;
  int unsigned results_seen   = 0;
  int unsigned windows_set    = 0;
  int unsigned overflows      = 0;
  int unsigned mismatches     = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  logic        steady_run     = 1'b0;
  logic        rx_steady      = 1'b0;
  logic        long_hold_done = 1'b0;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void pair_and_expire(input logic [TS_W-1:0] now);
    logic [TS_W-1:0] r, c, span, bound;
    longint          sum;
    while (ref_ts_q.size() != 0 && cand_ts_q.size() != 0) begin
      r    = ref_ts_q[0];
      c    = cand_ts_q[0];
      span = (c >= r) ? c - r : r - c;
      if (span <= TS_W'(window_us)) begin
        matched_n = sat_inc(matched_n);
        sum = delta_acc + (longint'({16'd0, c}) - longint'({16'd0, r}));
        if (sum > SUM_HI) begin
          sum = SUM_HI;
        end else if (sum < SUM_LO) begin
          sum = SUM_LO;
        end
        delta_acc = sum;
        if (span > max_dist) max_dist = span;
        void'(ref_ts_q.pop_front());
        void'(cand_ts_q.pop_front());
      end else if (r < c) begin
        ref_only_n = sat_inc(ref_only_n);
        void'(ref_ts_q.pop_front());
      end else begin
        cand_only_n = sat_inc(cand_only_n);
        void'(cand_ts_q.pop_front());
      end
    end
    // nothing expires while the match time is within one window of zero
    bound = (now > TS_W'(window_us)) ? now - TS_W'(window_us) : '0;
    while (ref_ts_q.size() != 0 && ref_ts_q[0] < bound) begin
      ref_only_n = sat_inc(ref_only_n);
      void'(ref_ts_q.pop_front());
    end
    while (cand_ts_q.size() != 0 && cand_ts_q[0] < bound) begin
      cand_only_n = sat_inc(cand_only_n);
      void'(cand_ts_q.pop_front());
    end
  endfunction

  function automatic tally_t predict_tally(input logic [OP_W-1:0] op,
                                           input logic [TS_W-1:0] ts);
    tally_t t;
    if (op == tepm_pkg::OP_PUSH_REF) begin
      ref_total_n = sat_inc(ref_total_n);
      if (ref_ts_q.size() >= tepm_pkg::QUEUE_DEPTH) begin
        ref_only_n = sat_inc(ref_only_n);
        overflows++;
        void'(ref_ts_q.pop_front());
      end
      ref_ts_q.push_back(ts);
    end else if (op == tepm_pkg::OP_PUSH_CAND) begin
      cand_total_n = sat_inc(cand_total_n);
      if (cand_ts_q.size() >= tepm_pkg::QUEUE_DEPTH) begin
        cand_only_n = sat_inc(cand_only_n);
        overflows++;
        void'(cand_ts_q.pop_front());
      end
      cand_ts_q.push_back(ts);
    end else if (op == tepm_pkg::OP_MATCH) begin
      pair_and_expire(ts);
    end
    t.matched    = matched_n;
    t.ref_only   = ref_only_n;
    t.cand_only  = cand_only_n;
    t.ref_total  = ref_total_n;
    t.cand_total = cand_total_n;
    t.delta_sum  = delta_acc[TS_W-1:0];
    t.max_abs    = max_dist;
    t.ref_pend   = PEND_W'(ref_ts_q.size());
    t.cand_pend  = PEND_W'(cand_ts_q.size());
    return t;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TS_W-1:0];
  endfunction

  task automatic add_job(input job_kind_e kind, input logic [OP_W-1:0] op,
                         input logic [TS_W-1:0] ts);
    job_q.push_back('{kind: kind, op: op, ts: ts});
  endtask

  // well-formed event traffic around a moving current time, with some noise
  task automatic add_scene(input logic [WIN_W-1:0] win, input int unsigned count);
    logic [TS_W-1:0] now;
    logic [63:0]     spread;
    logic [OP_W-1:0] side;
    int unsigned     made, r, n;
    logic            settled;
    spread  = 64'(win) + 64'(win >> 2) + 64'd2;
    now     = ($urandom_range(0, 3) == 0) ? '0 : rand_ts() >> 1;
    made    = 0;
    settled = 1'b0;
    add_job(K_WINDOW, tepm_pkg::OP_PUSH_REF, TS_W'(win));
    while (made < count) begin
      if (!settled && made >= count / 2) begin
        add_job(K_SETTLE, tepm_pkg::OP_PUSH_REF, '0);
        settled = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_job(K_EVENT, OP_W'($urandom_range(0, 3)), rand_ts());
        made++;
      end else if (r < 9) begin
        // one side only, 15 to 20 pushes, which can overflow its queue
        side = ($urandom_range(0, 1) == 0) ? tepm_pkg::OP_PUSH_REF : tepm_pkg::OP_PUSH_CAND;
        n    = $urandom_range(15, 20);
        repeat (n) add_job(K_EVENT, side, now + TS_W'({$urandom, $urandom} % spread));
        made += n;
      end else if (r < 12) begin
        now = now + TS_W'(spread * 2);
        add_job(K_EVENT, tepm_pkg::OP_MATCH, now);
        made++;
      end else if (r < 30) begin
        add_job(K_EVENT, tepm_pkg::OP_MATCH, now);
        made++;
      end else begin
        side = ($urandom_range(0, 1) == 0) ? tepm_pkg::OP_PUSH_REF : tepm_pkg::OP_PUSH_CAND;
        add_job(K_EVENT, side, now + TS_W'({$urandom, $urandom} % spread));
        now = now + TS_W'({$urandom, $urandom} % (spread / 4 + 1));
        made++;
      end
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    job_t head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      cfg_valid_i   <= 1'b0;
      cfg_data_i    <= '0;
      gap_left      <= 0;
      steady_run    <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the offered transaction
    end else if (cfg_valid_i && !cfg_ready_o) begin
      // hold the window write
    end else if (gap_left != 0) begin
      gap_left      <= gap_left - 1;
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else if (job_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      head = job_q[0];
      if (head.kind == K_EVENT) begin
        void'(job_q.pop_front());
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= head.ts;
        s_axis_tuser  <= head.op;
        cfg_valid_i   <= 1'b0;
        gap_left      <= steady_run ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
        // the block is idle once every accepted event has produced its result
        if (!s_axis_tvalid && !cfg_valid_i && events_in == results_seen) begin
          void'(job_q.pop_front());
          steady_run  <= ($urandom_range(0, 2) == 0);
          cfg_valid_i <= (head.kind == K_WINDOW);
          cfg_data_i  <= head.ts[WIN_W-1:0];
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin : sink_p
    int unsigned g;
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
      rx_steady      <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_steady <= !rx_steady;
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD;
        m_axis_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        g = rx_steady ? 0 : pick_gap();
        if (g == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold_left     <= g - 1;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : watch_p
    tally_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        window_us = cfg_data_i;
        windows_set++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tally_due_q.push_back(predict_tally(s_axis_tuser, s_axis_tdata));
        events_in <= events_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        got = m_axis_tdata[OUT_FIELDS_W-1:0];
        if (tally_due_q.size() == 0) begin
          $display("%0t ns: result transaction with nothing expected, actual 0x%0h",
                   $time, got);
          mismatches++;
        end else begin
          want = tally_due_q.pop_front();
          check_field("matched_count", want.matched, got.matched);
          check_field("reference_only_count", want.ref_only, got.ref_only);
          check_field("candidate_only_count", want.cand_only, got.cand_only);
          check_field("reference_total", want.ref_total, got.ref_total);
          check_field("candidate_total", want.cand_total, got.cand_total);
          check_field("delta_sum_us", want.delta_sum, got.delta_sum);
          check_field("max_abs_delta_us", want.max_abs, got.max_abs);
          check_field("reference_pending", want.ref_pend, got.ref_pend);
          check_field("candidate_pending", want.cand_pend, got.cand_pend);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim_p
    logic [WIN_W-1:0] windows[8];
    windows = '{24'd0, 24'hFFFFFF, 24'd1, 24'd1000, WIN_W'($urandom),
                24'd50000, WIN_W'($urandom_range(0, 100000)), 24'd200};

    // directed part, window at its reset value
    add_job(K_EVENT, tepm_pkg::OP_MATCH, '0);          // match on empty queues
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, '0);
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, '0);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, '0);          // zero distance pair
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, 48'd1000);
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, 48'd51000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd1000);    // distance exactly one window
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, 48'd2000);
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, 48'd52001);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd2000);    // one past: earlier reference dropped
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, 48'd500000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd500000);  // earlier candidate dropped
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, 48'd470000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd470000);  // negative delta
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, 48'd600000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd650000);  // on the expiry bound, kept
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd650001);  // just past it, expired
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, 48'd700000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, 48'd800000);  // candidate expired
    add_job(K_EVENT, OP_UNUSED, TS_MAX);               // unused code leaves state alone
    add_job(K_EVENT, tepm_pkg::OP_PUSH_REF, TS_MAX);
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, TS_MAX - 48'd50000);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, TS_MAX);
    add_job(K_EVENT, tepm_pkg::OP_PUSH_CAND, TS_MAX);
    add_job(K_EVENT, tepm_pkg::OP_MATCH, '0);
    add_job(K_SETTLE, tepm_pkg::OP_PUSH_REF, '0);

    foreach (windows[i]) add_scene(windows[i], SCENE_ITEMS);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_q.size() != 0 || s_axis_tvalid || cfg_valid_i || events_in != results_seen)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (tally_due_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, tally_due_q.size());
      mismatches++;
    end
    $display("run: %0d events, %0d results, %0d window writes, %0d matched pairs",
             events_in, results_seen, windows_set, matched_n);
    $display("     %0d queue overflows, %0d mismatching fields", overflows, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tepm_pkg.sv
src/tepm_queue.sv
src/timestamp_event_pair_matcher.sv
test/tb_timestamp_event_pair_matcher.sv
